### src/fust_pkg.sv
package fust_pkg;

    localparam int LETTER_W = 5;
    localparam int DATA_W   = 8;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [1:0]          t_count;

    localparam t_count CNT_ZERO = 2'd0;
    localparam t_count CNT_ONE  = 2'd1;
    localparam t_count CNT_TWO  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_QRD  = 4'b0100,
        ST_CRD  = 4'b1000
    } t_state;

    // command group from the sequencer to the count store
    typedef struct packed {
        logic   clear;
        logic   wr;
        t_count wdata;
    } t_cnt_ctl;

    typedef struct packed {
        logic    has;
        t_letter idx;
    } t_result;

endpackage

### src/fust_count_mem.sv
module fust_count_mem
    import fust_pkg::*;
#(
    parameter int ALPHABET = 26,
    parameter int AW       = $clog2(ALPHABET)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cnt_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_raddr,
    output t_count        o_rdata
);

    t_count               r_mem [ALPHABET];
    t_count               r_rdata;
    logic [ALPHABET-1:0]  r_valid;
    logic                 r_rvalid;

    // one valid bit per letter, so a clear takes effect at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.wr) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= !i_ctl.clear && (int'(i_raddr) < ALPHABET) && r_valid[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rvalid ? r_rdata : CNT_ZERO;

endmodule

### src/fust_queue_mem.sv
module fust_queue_mem
    import fust_pkg::*;
#(
    parameter int ALPHABET = 26,
    parameter int AW       = $clog2(ALPHABET)
) (
    input  logic          i_clk,
    input  logic          i_wen,
    input  logic [AW-1:0] i_waddr,
    input  t_letter       i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_letter       o_rdata
);

    t_letter r_mem [ALPHABET];
    t_letter r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/fust_out_buf.sv
module fust_out_buf
    import fust_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  t_result           i_res,
    output logic              o_space,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,
    output logic              o_m_tuser
);

    t_result r_out;
    t_result r_pend;
    logic    r_out_v;
    logic    r_pend_v;
    logic    slot_free;

    assign slot_free = !r_out_v || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (slot_free) begin
            if (r_pend_v) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end else begin
                r_out_v <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_pend_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_pend_v) begin
                r_out <= r_pend;
            end else if (i_res_valid) begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_pend <= i_res;
        end
    end

    // a new item may start only when the skid entry is free
    assign o_space    = !r_pend_v;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = DATA_W'(r_out.idx);
    assign o_m_tuser  = r_out.has;

endmodule

### src/fust_ctrl.sv
module fust_ctrl
    import fust_pkg::*;
#(
    parameter int ALPHABET = 26,
    parameter int AW       = $clog2(ALPHABET),
    parameter int FW       = $clog2(ALPHABET + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  t_letter       i_letter,
    input  logic          i_new_string,
    input  logic          i_buf_space,
    output logic          o_res_valid,
    output t_result       o_res,
    output t_cnt_ctl      o_cnt_ctl,
    output logic [AW-1:0] o_cnt_waddr,
    output logic [AW-1:0] o_cnt_raddr,
    input  t_count        i_cnt_rdata,
    output logic          o_q_wen,
    output logic [AW-1:0] o_q_waddr,
    output t_letter       o_q_wdata,
    output logic [AW-1:0] o_q_raddr,
    input  t_letter       i_q_rdata
);

    t_state        r_state, n_state;
    t_letter       r_letter, n_letter;
    t_letter       r_front, n_front;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic          accept;
    logic          in_range;
    logic          do_pop;
    logic          show_front;

    function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
        return (p == AW'(ALPHABET - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_s_tready = (r_state == ST_IDLE) && i_buf_space;
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_range   = int'(r_letter) < ALPHABET;

    assign o_cnt_waddr = AW'(r_letter);
    assign o_cnt_raddr = (r_state == ST_QRD) ? AW'(i_q_rdata) : AW'(i_letter);
    assign o_q_waddr   = r_tail;
    assign o_q_wdata   = r_letter;
    assign o_q_raddr   = n_head;

    always_comb begin
        n_state          = r_state;
        n_letter         = r_letter;
        n_front          = r_front;
        n_head           = r_head;
        n_tail           = r_tail;
        n_fill           = r_fill;
        o_cnt_ctl.clear  = accept && i_new_string;
        o_cnt_ctl.wr     = 1'b0;
        o_cnt_ctl.wdata  = CNT_ONE;
        o_q_wen          = 1'b0;
        o_res_valid      = 1'b0;
        o_res.has        = 1'b0;
        o_res.idx        = '0;
        do_pop           = 1'b0;
        show_front       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_letter = i_letter;
                    if (i_new_string) begin
                        n_head = '0;
                        n_tail = '0;
                        n_fill = '0;
                    end
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (in_range && i_cnt_rdata == CNT_ZERO) begin
                    o_cnt_ctl.wr    = 1'b1;
                    o_cnt_ctl.wdata = CNT_ONE;
                    if (r_fill < FW'(ALPHABET)) begin
                        o_q_wen = 1'b1;
                        n_tail  = wrap_next(r_tail);
                        n_fill  = r_fill + 1'b1;
                    end
                    // first letter of an empty queue becomes the front
                    if (r_fill == '0) begin
                        n_front = r_letter;
                    end
                    o_res_valid = 1'b1;
                    o_res.has   = 1'b1;
                    o_res.idx   = (r_fill == '0) ? r_letter : r_front;
                    n_state     = ST_IDLE;
                end else if (in_range && i_cnt_rdata == CNT_ONE) begin
                    o_cnt_ctl.wr    = 1'b1;
                    o_cnt_ctl.wdata = CNT_TWO;
                    // only the front can turn repeated here, others stay queued
                    if (r_fill != '0 && r_letter == r_front) begin
                        do_pop = 1'b1;
                    end else begin
                        show_front = 1'b1;
                    end
                end else begin
                    show_front = 1'b1;
                end
            end
            ST_QRD: begin
                n_front = i_q_rdata;
                n_state = ST_CRD;
            end
            ST_CRD: begin
                if (i_cnt_rdata >= CNT_TWO) begin
                    do_pop = 1'b1;
                end else begin
                    show_front = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (show_front) begin
            o_res_valid = 1'b1;
            o_res.has   = (r_fill != '0);
            o_res.idx   = (r_fill != '0) ? r_front : '0;
            n_state     = ST_IDLE;
        end

        if (do_pop) begin
            n_head = wrap_next(r_head);
            n_fill = r_fill - 1'b1;
            if (r_fill == FW'(1)) begin
                o_res_valid = 1'b1;
                o_res.has   = 1'b0;
                o_res.idx   = '0;
                n_state     = ST_IDLE;
            end else begin
                n_state = ST_QRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_letter <= n_letter;
        r_front  <= n_front;
    end

endmodule

### src/first_unique_symbol_tracker_top.sv
// flow: an accepted item reads the count memory in the update state, then its result
// goes to the output register; each front drop that leaves the order queue non-empty
// adds the queue read and count read states; a new item is taken only in the idle state
// reset: synchronous active low; counts are cleared at once through per-letter valid
// bits, so there is no clearing pass; new_string clears the same way
module first_unique_symbol_tracker_top
    import fust_pkg::*;
#(
    parameter int ALPHABET = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,  // [4:0] letter_index
    input  logic              i_s_tuser,  // [0] new_string
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata,  // [4:0] unique_index
    output logic              o_m_tuser   // [0] has_unique
);

    localparam int AW = $clog2(ALPHABET);

    t_cnt_ctl      cnt_ctl;
    logic [AW-1:0] cnt_waddr;
    logic [AW-1:0] cnt_raddr;
    t_count        cnt_rdata;
    logic          q_wen;
    logic [AW-1:0] q_waddr;
    t_letter       q_wdata;
    logic [AW-1:0] q_raddr;
    t_letter       q_rdata;
    logic          buf_space;
    logic          res_valid;
    t_result       res;

    fust_ctrl #(
        .ALPHABET (ALPHABET)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_letter     (i_s_tdata[LETTER_W-1:0]),
        .i_new_string (i_s_tuser),
        .i_buf_space  (buf_space),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_cnt_ctl    (cnt_ctl),
        .o_cnt_waddr  (cnt_waddr),
        .o_cnt_raddr  (cnt_raddr),
        .i_cnt_rdata  (cnt_rdata),
        .o_q_wen      (q_wen),
        .o_q_waddr    (q_waddr),
        .o_q_wdata    (q_wdata),
        .o_q_raddr    (q_raddr),
        .i_q_rdata    (q_rdata)
    );

    fust_count_mem #(
        .ALPHABET (ALPHABET)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_waddr (cnt_waddr),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    fust_queue_mem #(
        .ALPHABET (ALPHABET)
    ) u_queue_mem (
        .i_clk   (i_clk),
        .i_wen   (q_wen),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    fust_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (buf_space),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

### src/fust_checker.sv
module fust_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // no unique letter reports index zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 8'd0)
        else $error("empty result with nonzero index");

    // padding bits above the letter stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:5] == 3'd0)
        else $error("result padding not zero");

    // one item in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted while previous item still in work");

endmodule

bind first_unique_symbol_tracker_top fust_checker u_fust_checker (.*);
